>>> rtl/sot_pkg.sv
// ----------------------------------------------------------------------------
// sot_pkg
// Types and constants shared by the segment overlap test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sot_pkg;

    localparam int FIELD_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 30;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TOL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_TOL = 1'd1;

    localparam int UTOL_W = 30;
    localparam int PTOL_W = 16;
    localparam logic [UTOL_W-1:0] UTOL_RESET = 30'd10737;
    localparam logic [PTOL_W-1:0] PTOL_RESET = 16'd1;

    // Unit vectors are Q2.30, signed.
    localparam int UNIT_W     = 32;
    localparam int FRAC_SHIFT = 30;
    localparam int NORM_W     = 31;
    localparam int ROOT_W     = 32;
    localparam int QUOT_W     = 31;

    // Front end, square root, divide and sign stages of one unit vector.
    localparam int UNIT_LAT = 5 + ROOT_W + QUOT_W + 1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_start_x;
        logic signed [FIELD_W-1:0] a_start_y;
        logic signed [FIELD_W-1:0] a_dir_x;
        logic signed [FIELD_W-1:0] a_dir_y;
        logic signed [FIELD_W-1:0] b_start_x;
        logic signed [FIELD_W-1:0] b_start_y;
        logic signed [FIELD_W-1:0] b_dir_x;
        logic signed [FIELD_W-1:0] b_dir_y;
    } sot_in_t;

    typedef struct packed {
        logic parallel;
        logic overlap;
        logic b_inside_a;
    } sot_out_t;

endpackage

`default_nettype wire

>>> rtl/sot_unit.sv
// ----------------------------------------------------------------------------
// sot_unit
// Pipelined Q2.30 unit vector of a signed 2D vector: normalize, square,
// bit-per-stage square root, and bit-per-stage division of each component.
// ----------------------------------------------------------------------------
`default_nettype none

module sot_unit #(
    parameter int IW = 34
) (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic signed [IW-1:0]           x,
    input  wire logic signed [IW-1:0]           y,
    output logic signed [sot_pkg::UNIT_W-1:0]   ux,
    output logic signed [sot_pkg::UNIT_W-1:0]   uy
);
    import sot_pkg::*;

    localparam int PW    = $clog2(IW);
    localparam int EW    = IW + NORM_W;
    localparam int SQ_W  = 2 * NORM_W;
    localparam int REM_W = SQ_W + 1;
    localparam int TR_W  = REM_W + 2;
    localparam int DV_W  = NORM_W + FRAC_SHIFT + 2;

    // flags: {zero, sign x, sign y}
    logic [IW-1:0]     ax1_reg, ay1_reg, m1_reg;
    logic [2:0]        fl1_reg;
    logic [IW-1:0]     ax2_reg, ay2_reg;
    logic [PW-1:0]     p2_reg;
    logic [2:0]        fl2_reg;
    logic [NORM_W-1:0] nx3_reg, ny3_reg;
    logic [2:0]        fl3_reg;
    logic [SQ_W-1:0]   sqx4_reg, sqy4_reg;
    logic [NORM_W-1:0] nx4_reg, ny4_reg;
    logic [2:0]        fl4_reg;

    logic [REM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic [NORM_W-1:0] cx_reg   [0:ROOT_W];
    logic [NORM_W-1:0] cy_reg   [0:ROOT_W];
    logic [2:0]        cf_reg   [0:ROOT_W];

    logic [DV_W-1:0]   rx_reg [1:QUOT_W];
    logic [DV_W-1:0]   ry_reg [1:QUOT_W];
    logic [QUOT_W-1:0] qx_reg [1:QUOT_W];
    logic [QUOT_W-1:0] qy_reg [1:QUOT_W];
    logic [ROOT_W-1:0] dn_reg [1:QUOT_W];
    logic [2:0]        df_reg [1:QUOT_W];

    logic [IW-1:0]     ax_next, ay_next;
    logic [PW-1:0]     p_next;
    logic [EW-1:0]     shx, shy;
    logic [6:0]        shamt;

    always_comb
    begin
        ax_next = x[IW-1] ? IW'(-x) : IW'(x);
        ay_next = y[IW-1] ? IW'(-y) : IW'(y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= ax_next;
            ay1_reg <= ay_next;
            m1_reg  <= (ax_next > ay_next) ? ax_next : ay_next;
            fl1_reg <= {(ax_next == '0) && (ay_next == '0), x[IW-1], y[IW-1]};
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (m1_reg[i])
            begin
                p_next = PW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            p2_reg  <= p_next;
            fl2_reg <= fl1_reg;
        end
    end

    always_comb
    begin
        if (int'(p2_reg) >= FRAC_SHIFT)
        begin
            shamt = 7'(int'(p2_reg) - FRAC_SHIFT);
            shx   = EW'(ax2_reg) >> shamt;
            shy   = EW'(ay2_reg) >> shamt;
        end
        else
        begin
            shamt = 7'(FRAC_SHIFT - int'(p2_reg));
            shx   = EW'(ax2_reg) << shamt;
            shy   = EW'(ay2_reg) << shamt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx3_reg  <= shx[NORM_W-1:0];
            ny3_reg  <= shy[NORM_W-1:0];
            fl3_reg  <= fl2_reg;
            sqx4_reg <= SQ_W'(nx3_reg) * SQ_W'(nx3_reg);
            sqy4_reg <= SQ_W'(ny3_reg) * SQ_W'(ny3_reg);
            nx4_reg  <= nx3_reg;
            ny4_reg  <= ny3_reg;
            fl4_reg  <= fl3_reg;
            rem_reg[0]  <= REM_W'(sqx4_reg) + REM_W'(sqy4_reg);
            root_reg[0] <= '0;
            cx_reg[0]   <= nx4_reg;
            cy_reg[0]   <= ny4_reg;
            cf_reg[0]   <= fl4_reg;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - j;
        logic [TR_W-1:0] trial;

        assign trial = (TR_W'(root_reg[j]) << (B + 1)) + (TR_W'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (TR_W'(rem_reg[j]) >= trial)
                begin
                    rem_reg[j+1]  <= rem_reg[j] - trial[REM_W-1:0];
                    root_reg[j+1] <= root_reg[j] | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[j+1]  <= rem_reg[j];
                    root_reg[j+1] <= root_reg[j];
                end
                cx_reg[j+1] <= cx_reg[j];
                cy_reg[j+1] <= cy_reg[j];
                cf_reg[j+1] <= cf_reg[j];
            end
        end
    end

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_div
        localparam int B = QUOT_W - 1 - j;
        logic [DV_W-1:0]   rx, ry, cmp;
        logic [QUOT_W-1:0] qx, qy;
        logic [ROOT_W-1:0] dn;
        logic [2:0]        df;

        if (j == 0)
        begin : g_first
            assign rx = DV_W'(cx_reg[ROOT_W]) << FRAC_SHIFT;
            assign ry = DV_W'(cy_reg[ROOT_W]) << FRAC_SHIFT;
            assign qx = '0;
            assign qy = '0;
            assign dn = root_reg[ROOT_W];
            assign df = cf_reg[ROOT_W];
        end
        else
        begin : g_rest
            assign rx = rx_reg[j];
            assign ry = ry_reg[j];
            assign qx = qx_reg[j];
            assign qy = qy_reg[j];
            assign dn = dn_reg[j];
            assign df = df_reg[j];
        end

        assign cmp = DV_W'(dn) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rx >= cmp)
                begin
                    rx_reg[j+1] <= rx - cmp;
                    qx_reg[j+1] <= qx | (QUOT_W'(1) << B);
                end
                else
                begin
                    rx_reg[j+1] <= rx;
                    qx_reg[j+1] <= qx;
                end
                if (ry >= cmp)
                begin
                    ry_reg[j+1] <= ry - cmp;
                    qy_reg[j+1] <= qy | (QUOT_W'(1) << B);
                end
                else
                begin
                    ry_reg[j+1] <= ry;
                    qy_reg[j+1] <= qy;
                end
                dn_reg[j+1] <= dn;
                df_reg[j+1] <= df;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (df_reg[QUOT_W][2])
            begin
                ux <= '0;
                uy <= '0;
            end
            else
            begin
                ux <= df_reg[QUOT_W][1] ? -UNIT_W'(qx_reg[QUOT_W]) : UNIT_W'(qx_reg[QUOT_W]);
                uy <= df_reg[QUOT_W][0] ? -UNIT_W'(qy_reg[QUOT_W]) : UNIT_W'(qy_reg[QUOT_W]);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/segment_overlap_test.sv
// ----------------------------------------------------------------------------
// segment_overlap_test
// Parallel, overlap and containment flags for two 2D segments.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock unless stalled and returns each
// result in order. Depth comes from the unit vector units: a 32-stage square
// root then a 31-stage divider, one result bit per stage, plus normalization
// in front and the tolerance compare behind. A result that is not taken holds
// in the output register and stalls the whole pipeline, input included. The
// user writes tolerance registers through the configuration port only while
// no transaction is in flight; the block does not enforce it.
`default_nettype none

module segment_overlap_test #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire sot_pkg::sot_in_t                  in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output sot_pkg::sot_out_t                      out_data,
    input  wire logic                              cfg_we,
    input  wire logic [sot_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [sot_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sot_pkg::*;

    localparam int CW          = COORD_WIDTH;
    localparam int OW          = CW + 2;
    localparam int LW          = CW + 1;
    localparam int LH          = (LW + 1) / 2;
    localparam int LHI         = LW - LH;
    localparam int SQW         = 2 * LW;
    localparam int SIDE_LAST   = 6;
    localparam int CLOSE_FIRST = 1 + UNIT_LAT;
    localparam int FLAG_STAGE  = CLOSE_FIRST + 3;
    localparam int OUT_STAGE   = FLAG_STAGE + 1;
    localparam int SIDE_DLY    = FLAG_STAGE - SIDE_LAST;
    localparam int USQ_W       = 2 * UTOL_W;
    localparam int PSQ_W       = 2 * PTOL_W;

    function automatic logic signed [CW-1:0] to_coord(input logic signed [FIELD_W-1:0] f);
        logic signed [63:0] e;
        e = 64'($unsigned(f));
        return e[CW-1:0];
    endfunction

    function automatic logic [LW-1:0] dmag(input logic signed [CW-1:0] v);
        logic signed [CW:0] e;
        logic signed [CW:0] n;
        e = (CW+1)'(v);
        n = -e;
        return e[CW] ? LW'(n) : LW'(e);
    endfunction

    function automatic logic [LW-1:0] omag(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] n;
        n = -v;
        return v[OW-1] ? n[LW-1:0] : v[LW-1:0];
    endfunction

    logic                en;
    logic [OUT_STAGE:1]  vld_reg;

    logic [UTOL_W-1:0]   utol_reg;
    logic [PTOL_W-1:0]   ptol_reg;
    logic [USQ_W-1:0]    utol_sq_reg;
    logic [PSQ_W-1:0]    ptol_sq_reg;

    assign en        = out_ready | ~vld_reg[OUT_STAGE];
    assign in_ready  = en;
    assign out_valid = vld_reg[OUT_STAGE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[OUT_STAGE-1:1], in_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utol_reg <= UTOL_RESET;
            ptol_reg <= PTOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_UNIT_TOL:  utol_reg <= cfg_wdata[UTOL_W-1:0];
                REG_POINT_TOL: ptol_reg <= cfg_wdata[PTOL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        utol_sq_reg <= USQ_W'(utol_reg) * USQ_W'(utol_reg);
        ptol_sq_reg <= PSQ_W'(ptol_reg) * PSQ_W'(ptol_reg);
    end

    // Stage 1: coordinates, end points and the four point offsets.
    logic signed [CW-1:0] asx, asy, bsx, bsy, adx, ady, bdx, bdy;
    logic signed [CW:0]   aex, aey, bex, bey;
    logic signed [CW-1:0] adx_reg, ady_reg, bdx_reg, bdy_reg;
    logic signed [OW-1:0] offx_reg [0:3];
    logic signed [OW-1:0] offy_reg [0:3];

    assign asx = to_coord(in_data.a_start_x);
    assign asy = to_coord(in_data.a_start_y);
    assign adx = to_coord(in_data.a_dir_x);
    assign ady = to_coord(in_data.a_dir_y);
    assign bsx = to_coord(in_data.b_start_x);
    assign bsy = to_coord(in_data.b_start_y);
    assign bdx = to_coord(in_data.b_dir_x);
    assign bdy = to_coord(in_data.b_dir_y);
    assign aex = (CW+1)'(asx) + (CW+1)'(adx);
    assign aey = (CW+1)'(asy) + (CW+1)'(ady);
    assign bex = (CW+1)'(bsx) + (CW+1)'(bdx);
    assign bey = (CW+1)'(bsy) + (CW+1)'(bdy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adx_reg     <= adx;
            ady_reg     <= ady;
            bdx_reg     <= bdx;
            bdy_reg     <= bdy;
            offx_reg[0] <= OW'(bsx) - OW'(asx);
            offy_reg[0] <= OW'(bsy) - OW'(asy);
            offx_reg[1] <= OW'(bex) - OW'(asx);
            offy_reg[1] <= OW'(bey) - OW'(asy);
            offx_reg[2] <= OW'(asx) - OW'(bsx);
            offy_reg[2] <= OW'(asy) - OW'(bsy);
            offx_reg[3] <= OW'(aex) - OW'(bsx);
            offy_reg[3] <= OW'(aey) - OW'(bsy);
        end
    end

    // Unit vectors of both directions and of the four offsets.
    logic signed [UNIT_W-1:0] uax, uay, ubx, uby;
    logic signed [UNIT_W-1:0] wx [0:3];
    logic signed [UNIT_W-1:0] wy [0:3];

    sot_unit #(.IW(CW)) u_unit_a (
        .clk (clk),
        .en  (en),
        .x   (adx_reg),
        .y   (ady_reg),
        .ux  (uax),
        .uy  (uay)
    );

    sot_unit #(.IW(CW)) u_unit_b (
        .clk (clk),
        .en  (en),
        .x   (bdx_reg),
        .y   (bdy_reg),
        .ux  (ubx),
        .uy  (uby)
    );

    for (genvar k = 0; k < 4; k++)
    begin : g_off_unit
        sot_unit #(.IW(OW)) u_unit_o (
            .clk (clk),
            .en  (en),
            .x   (offx_reg[k]),
            .y   (offy_reg[k]),
            .ux  (wx[k]),
            .uy  (wy[k])
        );
    end

    // Side path: start coincidence and length checks for each point test.
    logic [3:0] len6, pt6;

    for (genvar k = 0; k < 4; k++)
    begin : g_side
        logic signed [CW-1:0] dx, dy;
        logic [LW-1:0]        mg_reg  [0:3];
        logic [2*LHI-1:0]     hh_reg  [0:3];
        logic [LHI+LH-1:0]    hl_reg  [0:3];
        logic [2*LH-1:0]      ll_reg  [0:3];
        logic [SQW-1:0]       sq_reg  [0:3];
        logic                 ltx_reg, lty_reg;
        logic [31:0]          p16x_reg, p16y_reg;
        logic                 pt4_reg, pt5_reg, pt6_reg;
        logic [SQW:0]         dsum_reg, osum_reg;
        logic                 len_reg;

        assign dx = (k < 2) ? adx_reg : bdx_reg;
        assign dy = (k < 2) ? ady_reg : bdy_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mg_reg[0] <= dmag(dx);
                mg_reg[1] <= dmag(dy);
                mg_reg[2] <= omag(offx_reg[k]);
                mg_reg[3] <= omag(offy_reg[k]);

                for (int v = 0; v < 4; v++)
                begin
                    hh_reg[v] <= (2*LHI)'(mg_reg[v][LW-1:LH]) * (2*LHI)'(mg_reg[v][LW-1:LH]);
                    hl_reg[v] <= (LHI+LH)'(mg_reg[v][LW-1:LH]) * (LHI+LH)'(mg_reg[v][LH-1:0]);
                    ll_reg[v] <= (2*LH)'(mg_reg[v][LH-1:0]) * (2*LH)'(mg_reg[v][LH-1:0]);
                end
                ltx_reg  <= mg_reg[2] < LW'(ptol_reg);
                lty_reg  <= mg_reg[3] < LW'(ptol_reg);
                p16x_reg <= 32'(mg_reg[2][15:0]) * 32'(mg_reg[2][15:0]);
                p16y_reg <= 32'(mg_reg[3][15:0]) * 32'(mg_reg[3][15:0]);

                for (int v = 0; v < 4; v++)
                begin
                    sq_reg[v] <= (SQW'(hh_reg[v]) << (2 * LH)) + (SQW'(hl_reg[v]) << (LH + 1))
                                 + SQW'(ll_reg[v]);
                end
                pt4_reg <= ltx_reg & lty_reg
                           & ((33'(p16x_reg) + 33'(p16y_reg)) < 33'(ptol_sq_reg));

                dsum_reg <= (SQW+1)'(sq_reg[0]) + (SQW+1)'(sq_reg[1]);
                osum_reg <= (SQW+1)'(sq_reg[2]) + (SQW+1)'(sq_reg[3]);
                pt5_reg  <= pt4_reg;

                len_reg <= dsum_reg >= osum_reg;
                pt6_reg <= pt5_reg;
            end
        end

        assign len6[k] = len_reg;
        assign pt6[k]  = pt6_reg;
    end

    logic [7:0] side_dly_reg [1:SIDE_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[1] <= {len6, pt6};
            for (int i = 2; i <= SIDE_DLY; i++)
            begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
        end
    end

    // Unit vector distance tests: parallel, antiparallel and four point tests.
    logic signed [UNIT_W-1:0] pu_x [0:5];
    logic signed [UNIT_W-1:0] pu_y [0:5];
    logic signed [UNIT_W-1:0] pv_x [0:5];
    logic signed [UNIT_W-1:0] pv_y [0:5];
    logic [UNIT_W-1:0]        dmx_reg [0:5];
    logic [UNIT_W-1:0]        dmy_reg [0:5];
    logic [2*UNIT_W-1:0]      sqx_reg [0:5];
    logic [2*UNIT_W-1:0]      sqy_reg [0:5];
    logic [5:0]               close_reg;

    always_comb
    begin
        pu_x[0] = uax;   pu_y[0] = uay;   pv_x[0] = ubx;   pv_y[0] = uby;
        pu_x[1] = uax;   pu_y[1] = uay;   pv_x[1] = -ubx;  pv_y[1] = -uby;
        pu_x[2] = uax;   pu_y[2] = uay;   pv_x[2] = wx[0]; pv_y[2] = wy[0];
        pu_x[3] = uax;   pu_y[3] = uay;   pv_x[3] = wx[1]; pv_y[3] = wy[1];
        pu_x[4] = ubx;   pu_y[4] = uby;   pv_x[4] = wx[2]; pv_y[4] = wy[2];
        pu_x[5] = ubx;   pu_y[5] = uby;   pv_x[5] = wx[3]; pv_y[5] = wy[3];
    end

    for (genvar j = 0; j < 6; j++)
    begin : g_close
        logic signed [UNIT_W:0] ddx, ddy, ndx, ndy;

        assign ddx = (UNIT_W+1)'(pu_x[j]) - (UNIT_W+1)'(pv_x[j]);
        assign ddy = (UNIT_W+1)'(pu_y[j]) - (UNIT_W+1)'(pv_y[j]);
        assign ndx = -ddx;
        assign ndy = -ddy;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dmx_reg[j]   <= ddx[UNIT_W] ? ndx[UNIT_W-1:0] : ddx[UNIT_W-1:0];
                dmy_reg[j]   <= ddy[UNIT_W] ? ndy[UNIT_W-1:0] : ddy[UNIT_W-1:0];
                sqx_reg[j]   <= (2*UNIT_W)'(dmx_reg[j]) * (2*UNIT_W)'(dmx_reg[j]);
                sqy_reg[j]   <= (2*UNIT_W)'(dmy_reg[j]) * (2*UNIT_W)'(dmy_reg[j]);
                close_reg[j] <= ((2*UNIT_W+1)'(sqx_reg[j]) + (2*UNIT_W+1)'(sqy_reg[j]))
                                < (2*UNIT_W+1)'(utol_sq_reg);
            end
        end
    end

    logic [3:0] len_f, pt_f, on_f;
    logic       par_f;

    assign len_f = side_dly_reg[SIDE_DLY][7:4];
    assign pt_f  = side_dly_reg[SIDE_DLY][3:0];
    assign on_f  = pt_f | (close_reg[5:2] & len_f);
    assign par_f = close_reg[0] | close_reg[1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data.parallel   <= par_f;
            out_data.overlap    <= par_f & (|on_f);
            out_data.b_inside_a <= on_f[0] & on_f[1];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sot_checker.sv
// ----------------------------------------------------------------------------
// sot_checker
// Port-level checks for segment_overlap_test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sot_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire sot_pkg::sot_out_t out_data
);

    // A transaction that is not taken stays on the output unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // Overlap is only reported for parallel segments.
    a_overlap_par: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_data.overlap || out_data.parallel)
        else $error("overlap reported without parallel");

    // A stalled output holds the whole pipeline, so no input is taken.
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");

endmodule

bind segment_overlap_test sot_checker u_sot_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

>>> dv/segment_overlap_test_tb.sv
// ----------------------------------------------------------------------------
// Segment overlap test testbench
// Drives pairs of 2D segments into the block, predicts the parallel, overlap
// and containment flags with an exact integer model, and compares every result
// in order. It runs through several tolerance settings and traffic patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_overlap_test_tb;
    import sot_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 90;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    sot_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sot_out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    sot_in_t pending_pairs[$];
    sot_out_t expected_flags[$];
    longint unsigned unit_tol = UTOL_RESET;
    longint unsigned point_tol = PTOL_RESET;
    int src_idle = 0;
    int snk_idle = 0;
    int stall_left = 0;
    bit stall_go = 1'b0;
    int mismatches = 0;
    int cycles = 0;
    int accepted = 0;
    int checked = 0;
    int n_par = 0;
    int n_ovl = 0;
    int n_ins = 0;

    segment_overlap_test u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_vec(input longint x, input longint y, output longint ux,
                                     output longint uy);
        longint unsigned ax, ay, m, n, qx, qy;
        ax = absval(x);
        ay = absval(y);
        m = ax > ay ? ax : ay;
        if (m == 0)
        begin
            ux = 0;
            uy = 0;
            return;
        end
        while (m >= (64'd1 << 31))
        begin
            ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 30))
        begin
            ax <<= 1; ay <<= 1; m <<= 1;
        end
        n = int_sqrt(ax * ax + ay * ay);
        qx = (ax << 30) / n;
        qy = (ay << 30) / n;
        ux = x < 0 ? -longint'(qx) : longint'(qx);
        uy = y < 0 ? -longint'(qy) : longint'(qy);
    endfunction

    function automatic bit units_near(longint ux, longint uy, longint vx, longint vy);
        longint unsigned dx, dy;
        dx = absval(ux - vx);
        dy = absval(uy - vy);
        return dx * dx + dy * dy < unit_tol * unit_tol;
    endfunction

    function automatic logic [127:0] sq_mag(longint x, longint y);
        logic [127:0] mx, my;
        mx = 128'(absval(x));
        my = 128'(absval(y));
        return mx * mx + my * my;
    endfunction

    function automatic bit point_on(longint sx, longint sy, longint dx, longint dy,
                                    longint ux, longint uy, longint px, longint py);
        longint ox, oy, wx, wy;
        longint unsigned mx, my;
        ox = px - sx;
        oy = py - sy;
        mx = absval(ox);
        my = absval(oy);
        if (mx < point_tol && my < point_tol && mx * mx + my * my < point_tol * point_tol)
            return 1'b1;
        unit_vec(ox, oy, wx, wy);
        if (!units_near(ux, uy, wx, wy))
            return 1'b0;
        return sq_mag(dx, dy) >= sq_mag(ox, oy);
    endfunction

    function automatic sot_out_t predict_flags(sot_in_t p);
        longint asx, asy, adx, ady, bsx, bsy, bdx, bdy;
        longint uax, uay, ubx, uby;
        bit par, bs_on, be_on;
        sot_out_t r;
        asx = longint'(p.a_start_x); asy = longint'(p.a_start_y);
        adx = longint'(p.a_dir_x);   ady = longint'(p.a_dir_y);
        bsx = longint'(p.b_start_x); bsy = longint'(p.b_start_y);
        bdx = longint'(p.b_dir_x);   bdy = longint'(p.b_dir_y);
        unit_vec(adx, ady, uax, uay);
        unit_vec(bdx, bdy, ubx, uby);
        par = units_near(uax, uay, ubx, uby) || units_near(uax, uay, -ubx, -uby);
        bs_on = point_on(asx, asy, adx, ady, uax, uay, bsx, bsy);
        be_on = point_on(asx, asy, adx, ady, uax, uay, bsx + bdx, bsy + bdy);
        r.parallel = par;
        r.overlap = par && (bs_on || be_on ||
                            point_on(bsx, bsy, bdx, bdy, ubx, uby, asx, asy) ||
                            point_on(bsx, bsy, bdx, bdy, ubx, uby, asx + adx, asy + ady));
        r.b_inside_a = bs_on && be_on;
        return r;
    endfunction

    function automatic sot_in_t make_pair();
        sot_in_t p;
        int kind, k, m, j, i;
        longint dx, dy, sx, sy;
        kind = $urandom_range(9);
        if (kind < 3)
            return {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
        k = $urandom_range(20);
        dx = longint'($signed($urandom_range((1 << k) * 2, 0))) - (1 << k);
        dy = longint'($signed($urandom_range((1 << k) * 2, 0))) - (1 << k);
        m = $urandom_range(8) - 4;
        j = $urandom_range(8) - 4;
        i = $urandom_range(8) - 4;
        sx = longint'($signed($urandom_range(1 << 25, 0))) - (1 << 24);
        sy = longint'($signed($urandom_range(1 << 25, 0))) - (1 << 24);
        p.a_start_x = 32'(sx);
        p.a_start_y = 32'(sy);
        p.a_dir_x = 32'(m * dx);
        p.a_dir_y = 32'(m * dy);
        p.b_start_x = 32'(sx + j * dx);
        p.b_start_y = 32'(sy + j * dy);
        p.b_dir_x = 32'(i * dx);
        p.b_dir_y = 32'(i * dy);
        if (kind == 9)
        begin
            p.b_start_x = 32'(longint'(p.b_start_x) + longint'($urandom_range(4)) - 2);
            p.b_dir_y = 32'(longint'(p.b_dir_y) + longint'($urandom_range(4)) - 2);
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_flags.push_back(predict_flags(in_data));
                accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= src_idle)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_pairs.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (stall_go)
        begin
            stall_left <= 400;
            stall_go <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_flags.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected transaction: %b", out_data);
                end
                else
                begin
                    sot_out_t e;
                    e = expected_flags.pop_front();
                    checked++;
                    n_par += e.parallel;
                    n_ovl += e.overlap;
                    n_ins += e.b_inside_a;
                    if (out_data.parallel !== e.parallel || out_data.overlap !== e.overlap
                        || out_data.b_inside_a !== e.b_inside_a)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch %0d: expected par=%b ovl=%b ins=%b, got %b %b %b",
                                     checked, e.parallel, e.overlap, e.b_inside_a,
                                     out_data.parallel, out_data.overlap, out_data.b_inside_a);
                    end
                end
            end
            out_ready <= (stall_left == 0) && ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        if (idx == REG_UNIT_TOL)
            unit_tol = val & ((64'd1 << UTOL_W) - 1);
        else
            point_tol = val & ((64'd1 << PTOL_W) - 1);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_pairs.size() > 0 || in_valid || expected_flags.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_pair(longint asx, longint asy, longint adx, longint ady,
                            longint bsx, longint bsy, longint bdx, longint bdy);
        sot_in_t p;
        p.a_start_x = 32'(asx); p.a_start_y = 32'(asy);
        p.a_dir_x = 32'(adx);   p.a_dir_y = 32'(ady);
        p.b_start_x = 32'(bsx); p.b_start_y = 32'(bsy);
        p.b_dir_x = 32'(bdx);   p.b_dir_y = 32'(bdy);
        pending_pairs.push_back(p);
    endtask

    task automatic add_random(int count);
        repeat (count) pending_pairs.push_back(make_pair());
    endtask

    task automatic add_directed();
        longint mx, mn;
        mx = 32'sh7FFFFFFF;
        mn = -64'sh80000000;
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 0, 1, 0, 0, 0);
        add_pair(0, 0, 65536, 0, 0, 0, 65536, 0);
        add_pair(0, 0, 262144, 0, 65536, 0, 65536, 0);
        add_pair(0, 0, 262144, 0, 65536, 0, -65536, 0);
        add_pair(0, 0, 65536, 65536, 65536, 65536, 65536, 65536);
        add_pair(0, 0, 65536, 0, 0, 0, 0, 65536);
        add_pair(0, 0, 65536, 0, 131072, 0, 65536, 0);
        add_pair(0, 0, 65536, 0, 65536, 0, 65536, 0);
        add_pair(mx, mx, mx, mx, mn, mn, mn, mn);
        add_pair(mn, mn, mn, mn, mn, mn, mn, mn);
        add_pair(mn, mx, mx, mn, mx, mn, mn, mx);
        add_pair(mx, 0, mn, 0, 0, 0, mx, 0);
        add_pair(0, 0, 1, 0, 0, 0, 1, 0);
        add_pair(0, 0, 3, 4, 0, 0, -3, -4);
        add_pair(5, 5, 0, 0, 5, 5, 7, 9);
        add_pair(-1, -1, 2, 2, 0, 0, 1, 1);
        add_pair(0, 0, 65536, 0, 0, 1, 65536, 0);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(REG_UNIT_TOL, CFG_DATA_W'(UTOL_RESET));
        write_reg(REG_POINT_TOL, CFG_DATA_W'(PTOL_RESET));
        add_directed();
        drain();

        src_idle = 23;
        snk_idle = 57;
        write_reg(REG_UNIT_TOL, CFG_DATA_W'(0));
        write_reg(REG_POINT_TOL, CFG_DATA_W'(0));
        add_directed();
        add_random(250);
        drain();

        write_reg(REG_UNIT_TOL, {CFG_DATA_W{1'b1}});
        write_reg(REG_POINT_TOL, {CFG_DATA_W{1'b1}});
        add_random(200);
        drain();

        src_idle = 57;
        snk_idle = 23;
        write_reg(REG_UNIT_TOL, CFG_DATA_W'($urandom_range(1 << 20)));
        write_reg(REG_POINT_TOL, CFG_DATA_W'($urandom));
        add_random(300);
        drain();

        src_idle = 0;
        snk_idle = 0;
        write_reg(REG_UNIT_TOL, CFG_DATA_W'(1));
        write_reg(REG_POINT_TOL, CFG_DATA_W'(16'hFFFF));
        stall_go <= 1'b1;
        add_random(300);
        drain();

        $display("Checked %0d of %0d transactions over five tolerance settings.",
                 checked, accepted);
        $display("Flags seen set: parallel %0d, overlap %0d, b inside a %0d.",
                 n_par, n_ovl, n_ins);
        if (mismatches == 0 && expected_flags.size() == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_flags.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
